// File: rtl/core/cau_pkg.sv
// Shared constants, types and the output clip function for the complex arithmetic unit.
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NUM_W     = 64 + FRAC_BITS;
  localparam int QUO_BITS  = 33;
  localparam int CMP_W     = 64 + QUO_BITS;
  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = $clog2(Q_DEPTH);

  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
    logic               zero_div;
  } item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } clip_t;

  // Sign and magnitude to 32-bit two's complement with saturation.
  function automatic clip_t clip(input logic neg, input logic [64:0] mag);
    clip_t c;
    c.sat = 1'b0;
    if (neg) begin
      if (mag > 65'h0_8000_0000) begin
        c.value = 32'h8000_0000;
        c.sat   = 1'b1;
      end else begin
        c.value = 32'(~mag[31:0] + 32'd1);
      end
    end else begin
      if (mag > 65'h0_7FFF_FFFF) begin
        c.value = 32'h7FFF_FFFF;
        c.sat   = 1'b1;
      end else begin
        c.value = mag[31:0];
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/core/cau_if.sv
// Valid/ready channel interfaces for operand items and result items.
interface cau_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] a_real;
  logic signed [31:0] a_imag;
  logic signed [31:0] b_real;
  logic signed [31:0] b_imag;

  modport source (output valid, command, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, command, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_real;
  logic signed [31:0] result_imag;
  logic               undefined;
  logic               saturated;

  modport source (output valid, result_real, result_imag, undefined, saturated, input ready);
  modport sink   (input valid, result_real, result_imag, undefined, saturated, output ready);
endinterface

// File: rtl/core/cau_front.sv
// Front end: accepts operand items and classifies them for the queue.
module cau_front (
  cau_in_if.sink         in_ch,
  input  logic           q_full,
  output logic           push,
  output cau_pkg::item_t item
);
  import cau_pkg::*;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  always_comb begin
    item.command  = in_ch.command;
    item.a_real   = in_ch.a_real;
    item.a_imag   = in_ch.a_imag;
    item.b_real   = in_ch.b_real;
    item.b_imag   = in_ch.b_imag;
    item.zero_div = (in_ch.command == CMD_DIV) && (in_ch.b_real == 32'sd0) &&
                    (in_ch.b_imag == 32'sd0);
  end

endmodule

// File: rtl/core/cau_queue.sv
// Short item queue between front end and execution pipeline.
module cau_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cau_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output cau_pkg::item_t rd_item
);
  import cau_pkg::*;

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_PTR_W:0]   count_r;

  assign full    = (count_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/cau_back.sv
// Execution pipeline: products, sums, rounding and a pipelined restoring divider.
module cau_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cau_pkg::item_t q_item,
  input  logic           q_empty,
  output logic           pop,
  cau_out_if.source      out_ch
);
  import cau_pkg::*;

  localparam logic [64:0] HALF = (65'd1 << FRAC_BITS) >> 1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               zero_div;
    logic [31:0]        as_rr;
    logic [31:0]        as_ri;
    logic               as_sat;
    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ri;
    logic signed [63:0] p_ir;
    logic signed [63:0] d_rr;
    logic signed [63:0] d_ii;
  } s1_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        zero_div;
    logic [31:0] as_rr;
    logic [31:0] as_ri;
    logic        as_sat;
    logic        re_neg;
    logic [63:0] re_mag;
    logic        im_neg;
    logic [63:0] im_mag;
    logic [63:0] den;
  } s2_t;

  typedef struct packed {
    logic                neg;
    logic                ovf;
    logic [NUM_W-1:0]    rem;
    logic [QUO_BITS-1:0] quo;
  } part_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        zero_div;
    logic [31:0] fin_rr;
    logic [31:0] fin_ri;
    logic        fin_sat;
    logic [63:0] den;
    part_t       re;
    part_t       im;
  } dv_t;

  typedef struct packed {
    logic [31:0] rr;
    logic [31:0] ri;
    logic        undef;
    logic        sat;
  } res_t;

  logic adv;
  logic s1_v_r, s2_v_r, out_valid_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  dv_t  dv_r   [QUO_BITS+1];
  dv_t  dv_nxt [QUO_BITS+1];
  logic dv_v_r [QUO_BITS+1];
  res_t out_r, out_nxt;

  // Whole pipeline moves together; stalls only when the output is held.
  assign adv = !out_valid_r || out_ch.ready;
  assign pop = adv && !q_empty;

  // Stage 1: add/sub resolved, all products formed.
  always_comb begin
    logic signed [32:0] sr, si;
    logic [32:0]        mr, mi;
    clip_t              cr, ci;
    if (q_item.command == CMD_SUB) begin
      sr = 33'($signed(q_item.a_real)) - 33'($signed(q_item.b_real));
      si = 33'($signed(q_item.a_imag)) - 33'($signed(q_item.b_imag));
    end else begin
      sr = 33'($signed(q_item.a_real)) + 33'($signed(q_item.b_real));
      si = 33'($signed(q_item.a_imag)) + 33'($signed(q_item.b_imag));
    end
    mr = sr[32] ? 33'(-sr) : 33'(sr);
    mi = si[32] ? 33'(-si) : 33'(si);
    cr = clip(sr[32], 65'(mr));
    ci = clip(si[32], 65'(mi));
    s1_nxt.cmd      = q_item.command;
    s1_nxt.zero_div = q_item.zero_div;
    s1_nxt.as_rr    = cr.value;
    s1_nxt.as_ri    = ci.value;
    s1_nxt.as_sat   = cr.sat || ci.sat;
    s1_nxt.p_rr     = 64'($signed(q_item.a_real)) * 64'($signed(q_item.b_real));
    s1_nxt.p_ii     = 64'($signed(q_item.a_imag)) * 64'($signed(q_item.b_imag));
    s1_nxt.p_ri     = 64'($signed(q_item.a_real)) * 64'($signed(q_item.b_imag));
    s1_nxt.p_ir     = 64'($signed(q_item.a_imag)) * 64'($signed(q_item.b_real));
    s1_nxt.d_rr     = 64'($signed(q_item.b_real)) * 64'($signed(q_item.b_real));
    s1_nxt.d_ii     = 64'($signed(q_item.b_imag)) * 64'($signed(q_item.b_imag));
  end

  // Stage 2: sums of products as sign and magnitude, divisor norm.
  always_comb begin
    logic signed [64:0] re_s, im_s;
    if (s1_r.cmd == CMD_DIV) begin
      re_s = 65'($signed(s1_r.p_rr)) + 65'($signed(s1_r.p_ii));
      im_s = 65'($signed(s1_r.p_ir)) - 65'($signed(s1_r.p_ri));
    end else begin
      re_s = 65'($signed(s1_r.p_rr)) - 65'($signed(s1_r.p_ii));
      im_s = 65'($signed(s1_r.p_ri)) + 65'($signed(s1_r.p_ir));
    end
    s2_nxt.cmd      = s1_r.cmd;
    s2_nxt.zero_div = s1_r.zero_div;
    s2_nxt.as_rr    = s1_r.as_rr;
    s2_nxt.as_ri    = s1_r.as_ri;
    s2_nxt.as_sat   = s1_r.as_sat;
    s2_nxt.re_neg   = re_s[64];
    s2_nxt.re_mag   = re_s[64] ? 64'(-re_s) : re_s[63:0];
    s2_nxt.im_neg   = im_s[64];
    s2_nxt.im_mag   = im_s[64] ? 64'(-im_s) : im_s[63:0];
    s2_nxt.den      = 64'(s1_r.d_rr) + 64'(s1_r.d_ii);
  end

  // Stage 3: multiply rounding; divider setup with quotient overflow check.
  always_comb begin
    logic [64:0]      rnd_r, rnd_i;
    logic [NUM_W-1:0] num_r, num_i;
    logic [CMP_W-1:0] den_top;
    clip_t            cr, ci;
    rnd_r   = (65'(s2_r.re_mag) + HALF) >> FRAC_BITS;
    rnd_i   = (65'(s2_r.im_mag) + HALF) >> FRAC_BITS;
    cr      = clip(s2_r.re_neg, rnd_r);
    ci      = clip(s2_r.im_neg, rnd_i);
    num_r   = NUM_W'(s2_r.re_mag) << FRAC_BITS;
    num_i   = NUM_W'(s2_r.im_mag) << FRAC_BITS;
    den_top = CMP_W'(s2_r.den) << QUO_BITS;
    dv_nxt[0].cmd      = s2_r.cmd;
    dv_nxt[0].zero_div = s2_r.zero_div;
    if (s2_r.cmd == CMD_MUL) begin
      dv_nxt[0].fin_rr  = cr.value;
      dv_nxt[0].fin_ri  = ci.value;
      dv_nxt[0].fin_sat = cr.sat || ci.sat;
    end else begin
      dv_nxt[0].fin_rr  = s2_r.as_rr;
      dv_nxt[0].fin_ri  = s2_r.as_ri;
      dv_nxt[0].fin_sat = s2_r.as_sat;
    end
    dv_nxt[0].den    = s2_r.den;
    dv_nxt[0].re.neg = s2_r.re_neg;
    dv_nxt[0].re.ovf = CMP_W'(num_r) >= den_top;
    dv_nxt[0].re.rem = num_r;
    dv_nxt[0].re.quo = '0;
    dv_nxt[0].im.neg = s2_r.im_neg;
    dv_nxt[0].im.ovf = CMP_W'(num_i) >= den_top;
    dv_nxt[0].im.rem = num_i;
    dv_nxt[0].im.quo = '0;
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
    localparam int K = QUO_BITS - 1 - j;
    always_comb begin
      logic [CMP_W-1:0] dsh;
      dsh       = CMP_W'(dv_r[j].den) << K;
      dv_nxt[j+1] = dv_r[j];
      if (CMP_W'(dv_r[j].re.rem) >= dsh) begin
        dv_nxt[j+1].re.rem    = dv_r[j].re.rem - NUM_W'(dsh);
        dv_nxt[j+1].re.quo[K] = 1'b1;
      end
      if (CMP_W'(dv_r[j].im.rem) >= dsh) begin
        dv_nxt[j+1].im.rem    = dv_r[j].im.rem - NUM_W'(dsh);
        dv_nxt[j+1].im.quo[K] = 1'b1;
      end
    end
  end

  // Final stage: round to nearest, saturate, select by command.
  always_comb begin
    logic [64:0] mag_r, mag_i;
    clip_t       cr, ci;
    dv_t         d;
    d     = dv_r[QUO_BITS];
    mag_r = 65'(d.re.quo) + 65'(({1'b0, d.re.rem[63:0]} << 1) >= 65'(d.den));
    mag_i = 65'(d.im.quo) + 65'(({1'b0, d.im.rem[63:0]} << 1) >= 65'(d.den));
    cr    = clip(d.re.neg, d.re.ovf ? (65'd1 << QUO_BITS) : mag_r);
    ci    = clip(d.im.neg, d.im.ovf ? (65'd1 << QUO_BITS) : mag_i);
    out_nxt.undef = 1'b0;
    if (d.cmd != CMD_DIV) begin
      out_nxt.rr  = d.fin_rr;
      out_nxt.ri  = d.fin_ri;
      out_nxt.sat = d.fin_sat;
    end else if (d.zero_div) begin
      out_nxt.rr    = '0;
      out_nxt.ri    = '0;
      out_nxt.sat   = 1'b0;
      out_nxt.undef = 1'b1;
    end else begin
      out_nxt.rr  = cr.value;
      out_nxt.ri  = ci.value;
      out_nxt.sat = cr.sat || ci.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      out_r <= out_nxt;
      for (int i = 0; i <= QUO_BITS; i++) begin
        dv_r[i] <= dv_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i <= QUO_BITS; i++) begin
        dv_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      s1_v_r    <= !q_empty;
      s2_v_r    <= s1_v_r;
      dv_v_r[0] <= s2_v_r;
      for (int i = 1; i <= QUO_BITS; i++) begin
        dv_v_r[i] <= dv_v_r[i-1];
      end
      out_valid_r <= dv_v_r[QUO_BITS];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_real = out_r.rr;
  assign out_ch.result_imag = out_r.ri;
  assign out_ch.undefined   = out_r.undef;
  assign out_ch.saturated   = out_r.sat;

endmodule

// File: rtl/core/complex_arithmetic_unit.sv
// Pipeline after the input queue: 3 arithmetic stages, 33 divider stages and 1 output stage.
// Throughput: one item per cycle; the divider is fully pipelined, one quotient bit per stage.
// A 2-entry queue decouples input accept from the pipeline; the pipeline halts as a whole
// while a result waits on out_ch.ready.
// Reset: synchronous active-low rst_n empties the queue and clears all pipeline valids.
module complex_arithmetic_unit (
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);
  import cau_pkg::*;

  logic  push, q_full, q_empty, pop;
  item_t wr_item, rd_item;

  cau_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .item   (wr_item)
  );

  cau_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_item (wr_item),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .rd_item (rd_item)
  );

  cau_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (rd_item),
    .q_empty (q_empty),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// File: rtl/core/cau_checker.sv
// Port-level checks for the complex arithmetic unit, bound to the top level.
module cau_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_real,
  input logic [31:0] result_imag,
  input logic        undefined,
  input logic        saturated
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(result_real) &&
    $stable(result_imag) && $stable(undefined) && $stable(saturated))
    else $error("stalled result changed");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && undefined |-> result_real == 32'd0 && result_imag == 32'd0 && !saturated)
    else $error("divide by zero result not cleared");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && saturated |->
    result_real == 32'h7FFF_FFFF || result_real == 32'h8000_0000 ||
    result_imag == 32'h7FFF_FFFF || result_imag == 32'h8000_0000)
    else $error("saturated flag without a clipped part");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .result_real (out_ch.result_real),
  .result_imag (out_ch.result_imag),
  .undefined   (out_ch.undefined),
  .saturated   (out_ch.saturated)
);

// File: tb/cau_checker.sv
// Watches both channels, predicts each result and compares it with the block's output.
`timescale 1ns / 100ps
module cau_scoreboard (
  input  logic clk,
  input  logic rst_n,
  cau_in_if    in_ch,
  cau_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   n_sat,
  output int   n_undef
);
  import cau_pkg::*;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        undef;
    logic        sat;
  } result_t;

  result_t expected_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    n_sat      = 0;
    n_undef    = 0;
  end

  // Signed magnitude to 32-bit two's complement, clipped.
  function automatic logic [31:0] clip32(input logic neg, input logic [127:0] mag,
                                         inout logic sat);
    if (neg) begin
      if (mag > 128'h8000_0000) begin
        sat = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-mag);
    end
    if (mag > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  // Multiply: exact sum of products, rounded half away from zero.
  function automatic logic [31:0] scale_round(input logic signed [127:0] v, inout logic sat);
    logic [127:0] mag;
    mag = v < 0 ? -v : v;
    mag = (mag + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return clip32(v < 0, mag, sat);
  endfunction

  // Divide: (v * 2^FRAC_BITS) / den, rounded half away from zero.
  function automatic logic [31:0] div_round(input logic signed [127:0] v,
                                            input logic [127:0] den, inout logic sat);
    logic [127:0] mag, q, r;
    mag = v < 0 ? -v : v;
    mag = mag << FRAC_BITS;
    q   = mag / den;
    r   = mag % den;
    if (2 * r >= den) q = q + 1;
    return clip32(v < 0, q, sat);
  endfunction

  function automatic result_t compute_result(input logic [1:0] cmd,
                                             input logic signed [31:0] ar, ai, br, bi);
    result_t res;
    logic signed [127:0] xr, xi, yr, yi;
    logic [127:0] den;
    logic sat;
    xr = ar; xi = ai; yr = br; yi = bi;
    sat = 1'b0;
    res = '0;
    case (cmd)
      CMD_ADD: begin
        res.re = clip32(xr + yr < 0, (xr + yr < 0) ? -(xr + yr) : xr + yr, sat);
        res.im = clip32(xi + yi < 0, (xi + yi < 0) ? -(xi + yi) : xi + yi, sat);
      end
      CMD_SUB: begin
        res.re = clip32(xr - yr < 0, (xr - yr < 0) ? -(xr - yr) : xr - yr, sat);
        res.im = clip32(xi - yi < 0, (xi - yi < 0) ? -(xi - yi) : xi - yi, sat);
      end
      CMD_MUL: begin
        res.re = scale_round(xr * yr - xi * yi, sat);
        res.im = scale_round(xr * yi + xi * yr, sat);
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          res.undef = 1'b1;
        end else begin
          res.re = div_round(xr * yr + xi * yi, den, sat);
          res.im = div_round(xi * yr - xr * yi, den, sat);
        end
      end
    endcase
    res.sat = sat;
    return res;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_q.push_back(compute_result(in_ch.command, in_ch.a_real, in_ch.a_imag,
                                          in_ch.b_real, in_ch.b_imag));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected item", {30'd0, out_ch.undefined, out_ch.saturated}, 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.result_real !== want.re) report("result_real", out_ch.result_real, want.re);
        if (out_ch.result_imag !== want.im) report("result_imag", out_ch.result_imag, want.im);
        if (out_ch.undefined !== want.undef)
          report("undefined", 32'(out_ch.undefined), 32'(want.undef));
        if (out_ch.saturated !== want.sat)
          report("saturated", 32'(out_ch.saturated), 32'(want.sat));
        n_sat   += want.sat;
        n_undef += want.undef;
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: tb/tb_top.sv
// Stimulus, flow control and verdict for the complex arithmetic unit.
`timescale 1ns / 100ps
module tb_top;
  import cau_pkg::*;

  localparam int N_RANDOM = 1400;
  localparam int LATENCY  = 37;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending, n_sat, n_undef;
  int   sent_count = 0;
  int   per_cmd[4] = '{0, 0, 0, 0};

  cau_in_if  in_ch ();
  cau_out_if out_ch ();

  complex_arithmetic_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  cau_scoreboard chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending), .n_sat(n_sat), .n_undef(n_undef)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] ar, ai, br, bi);
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.a_real  <= ar;
    in_ch.a_imag  <= ai;
    in_ch.b_real  <= br;
    in_ch.b_imag  <= bi;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    per_cmd[cmd]++;
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  // Mix of full-range, moderate, tiny and edge values.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2:    return 32'($signed($urandom_range(0, 32'h7_FFFF)) - 32'sh4_0000);
      3:    return 32'($signed($urandom_range(0, 32'h3FFF)) - 32'sh2000);
      4: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Receiver: random stall patterns, plus one long hold-off under load.
  initial begin
    int mode;
    bit held;
    out_ch.ready = 1'b0;
    held = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (!held && sent_count >= 300) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (200) @(negedge clk);
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= ($urandom_range(0, 9) < 8);
      endcase
    end
  end

  initial begin
    logic [1:0] cmd;
    logic [31:0] br, bi;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.a_real  = '0;
    in_ch.a_imag  = '0;
    in_ch.b_real  = '0;
    in_ch.b_imag  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: saturation at both ends, rounding ties, divide by zero, exact minimum.
    send_item(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
    send_item(CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(CMD_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(CMD_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0);
    send_item(CMD_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000, 32'h0);
    send_item(CMD_MUL, 32'h0000_0001, 32'h0000_0001, 32'h0000_7FFF, 32'h0000_7FFF);
    send_item(CMD_MUL, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'h0);
    send_item(CMD_DIV, 32'h1234_5678, 32'h8765_4321, 32'h0, 32'h0);
    send_item(CMD_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(CMD_DIV, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'h0);
    send_item(CMD_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
    send_item(CMD_DIV, 32'h0001_0000, 32'h0, 32'h8000_0000, 32'h8000_0000);
    send_item(CMD_DIV, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0000_0001);
    send_item(CMD_DIV, 32'h0000_0001, 32'h0, 32'h0002_0000, 32'h0);
    send_item(CMD_DIV, 32'hFFFF_FFFF, 32'h0, 32'h0002_0000, 32'h0);
    send_item(CMD_DIV, 32'h0003_0000, 32'h0, 32'h0, 32'h0003_0000);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 700) begin
        idle_cycles(1);
        wait (pending == 0);
      end
      cmd = 2'($urandom_range(0, 3));
      br  = pick_value();
      bi  = pick_value();
      if (cmd == CMD_DIV && $urandom_range(0, 15) == 0) begin
        br = '0;
        bi = '0;
      end
      send_item(cmd, pick_value(), pick_value(), br, bi);
      // bursts of random length with random gaps
      if ($urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 12));
    end
    idle_cycles(1);

    wait (pending == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d items: add %0d, sub %0d, mul %0d, div %0d", sent_count,
             per_cmd[CMD_ADD], per_cmd[CMD_SUB], per_cmd[CMD_MUL], per_cmd[CMD_DIV]);
    $display("Results with clipping %0d, with zero divisor %0d, mismatches %0d",
             n_sat, n_undef, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
